/* hw/rtl/pbh_pkg.sv */
// ============================================================================
// pbh_pkg : shared types and constants for the palette / blend / stretch block
// Request kinds, scale modes, register indexes, queue entry and blend weights.
// ============================================================================
package pbh_pkg;

  // Default palette depth; the top level may override it (16..256)
  localparam int PALETTE_DEPTH_DEF = 256;

  // Request kinds carried in in_tuser[0]
  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_PIXEL     = 1'b1;

  // Scale modes; the unused code behaves as native
  localparam logic [1:0] SCALE_NATIVE = 2'd0;
  localparam logic [1:0] SCALE_6TO7   = 2'd1;
  localparam logic [1:0] SCALE_6TO8   = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUR       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP       = 2'd2;

  // Column limits
  localparam logic [7:0] COL_CLIP_LO = 8'd8;
  localparam logic [7:0] COL_CLIP_HI = 8'd247;
  localparam logic [7:0] COL_LAST    = 8'd255;

  // Stretch group phase, i.e. (column - 8) mod 6; column 0 sits at phase 4
  localparam logic [2:0] PHASE_COL0 = 3'd4;
  localparam logic [2:0] PHASE_LAST = 3'd5;

  // Blend weights (percent) of the previous pixel, and of the current one
  localparam int W_RED   = 30;
  localparam int W_GREEN = 30;
  localparam int W_BLUE  = 20;
  localparam int W_FULL  = 100;
  localparam int MIX_W   = 15;   // 255 * 100 fits in 15 bits

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 25600
  localparam int RECIP_100   = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;

  // RGB565 field masks
  localparam logic [15:0] MASK_R = 16'd63488;
  localparam logic [15:0] MASK_G = 16'd2016;
  localparam logic [15:0] MASK_B = 16'd31;

  // Queue between front and back
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [1:0] scale_mode;
    logic       blur_enable;
    logic       clip_sides;
  } cfg_t;

  typedef struct packed {
    logic        is_write;  // palette write, else a kept pixel
    logic [7:0]  idx;       // palette entry or pixel index
    logic [7:0]  partner;   // blend partner index
    logic [23:0] rgb;       // colour for a palette write
    logic        blur;
    logic        twice;     // pixel emitted two times
    logic        eol;       // last output pixel of the line
  } entry_t;

endpackage

/* hw/rtl/pbh_ram.sv */
// ============================================================================
// pbh_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ============================================================================
module pbh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pbh_front.sv */
// ============================================================================
// pbh_front : request classification
// Tracks column, stretch phase and previous pixels; drops clipped columns and
// tags each kept pixel with its blend partner, repeat and end-of-line flags.
// ============================================================================
module pbh_front (
  input  logic            clk,
  input  logic            rst_n,
  input  pbh_pkg::cfg_t   cfg,
  input  logic            accept,
  input  logic            cmd,
  input  logic [7:0]      index,
  input  logic [23:0]     rgb,
  input  logic            line_start,
  output logic            push,
  output pbh_pkg::entry_t push_entry
);

  logic [7:0] column_r, column_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] kept_r, kept_nxt;

  logic [7:0] col;
  logic [2:0] phase;
  logic       stretch;
  logic       keep;
  logic       twice;
  logic       eol;
  logic       in_clip;
  logic       is_pixel;

  always_comb begin
    is_pixel = (cmd == pbh_pkg::CMD_PIXEL);
    col      = line_start ? 8'd0 : column_r;
    phase    = line_start ? pbh_pkg::PHASE_COL0 : phase_r;
    stretch  = (cfg.scale_mode == pbh_pkg::SCALE_6TO7) ||
               (cfg.scale_mode == pbh_pkg::SCALE_6TO8);
    in_clip  = (col >= pbh_pkg::COL_CLIP_LO) && (col <= pbh_pkg::COL_CLIP_HI);

    twice = 1'b0;
    if (stretch) begin
      keep = in_clip;
      eol  = (col == pbh_pkg::COL_CLIP_HI);
      if (cfg.scale_mode == pbh_pkg::SCALE_6TO7) begin
        twice = (phase == 3'd3);
      end else if (cfg.blur_enable) begin
        twice = (phase == 3'd0) || (phase == 3'd3);
      end else begin
        twice = (phase == 3'd1) || (phase == 3'd4);
      end
    end else begin
      keep = cfg.clip_sides ? in_clip : 1'b1;
      eol  = cfg.clip_sides ? (col == pbh_pkg::COL_CLIP_HI)
                            : (col == pbh_pkg::COL_LAST);
    end

    push               = accept && (!is_pixel || keep);
    push_entry.is_write = !is_pixel;
    push_entry.idx      = index;
    push_entry.partner  = stretch ? prev_r : kept_r;
    push_entry.rgb      = rgb;
    push_entry.blur     = cfg.blur_enable;
    push_entry.twice    = twice;
    push_entry.eol      = eol;

    column_nxt = column_r;
    phase_nxt  = phase_r;
    prev_nxt   = prev_r;
    kept_nxt   = kept_r;
    if (accept && is_pixel) begin
      column_nxt = col + 8'd1;
      if (col == pbh_pkg::COL_LAST) begin
        phase_nxt = pbh_pkg::PHASE_COL0;
      end else if (phase == pbh_pkg::PHASE_LAST) begin
        phase_nxt = 3'd0;
      end else begin
        phase_nxt = phase + 3'd1;
      end
      prev_nxt = index;
      if (!stretch && keep) begin
        kept_nxt = index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= 8'd0;
      phase_r  <= pbh_pkg::PHASE_COL0;
      prev_r   <= 8'd0;
      kept_r   <= 8'd0;
    end else begin
      column_r <= column_nxt;
      phase_r  <= phase_nxt;
      prev_r   <= prev_nxt;
      kept_r   <= kept_nxt;
    end
  end

endmodule

/* hw/rtl/pbh_queue.sv */
// ============================================================================
// pbh_queue : short request queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ============================================================================
module pbh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pbh_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output pbh_pkg::entry_t head_entry
);

  localparam int PW = $clog2(pbh_pkg::Q_DEPTH);
  localparam int CW = $clog2(pbh_pkg::Q_DEPTH + 1);

  pbh_pkg::entry_t store [pbh_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    full       = (count_r == CW'(pbh_pkg::Q_DEPTH));
    head_valid = (count_r != '0);
    head_entry = store[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/pbh_back.sv */
// ============================================================================
// pbh_back : palette lookup, blend, RGB565 pack and output repeat
// Stages: palette read, weighted sum, divide by 100 and pack, output register
// that gives a repeated pixel a second beat.
// ============================================================================
module pbh_back #(
  parameter int PALETTE_DEPTH = pbh_pkg::PALETTE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  pbh_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_pixel,
  output logic            out_last,
  output logic            out_eol
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);
  localparam logic [6:0] WC_R = 7'(pbh_pkg::W_FULL - pbh_pkg::W_RED);
  localparam logic [6:0] WC_G = 7'(pbh_pkg::W_FULL - pbh_pkg::W_GREEN);
  localparam logic [6:0] WC_B = 7'(pbh_pkg::W_FULL - pbh_pkg::W_BLUE);
  localparam logic [6:0] WP_R = 7'(pbh_pkg::W_RED);
  localparam logic [6:0] WP_G = 7'(pbh_pkg::W_GREEN);
  localparam logic [6:0] WP_B = 7'(pbh_pkg::W_BLUE);
  localparam logic [6:0] WF   = 7'(pbh_pkg::W_FULL);
  localparam int MW = pbh_pkg::MIX_W;
  localparam int PW = pbh_pkg::MIX_W + pbh_pkg::RECIP_W;
  localparam logic [pbh_pkg::RECIP_W-1:0] RECIP = pbh_pkg::RECIP_W'(pbh_pkg::RECIP_100);

  // handshake chain
  logic ld1, ld2, ld3, ldo;
  logic s1_free, s2_free, s3_free, o_free;
  logic out_fire;
  logic is_pixel;
  logic pal_we;

  // stage 1: palette read
  logic        s1_v_r;
  logic        s1_blur_r, s1_twice_r, s1_eol_r, s1_cur_oob_r, s1_prev_oob_r;
  logic [23:0] cur_raw, prev_raw;
  logic [23:0] cur_c, prev_c;

  // stage 2: weighted sums
  logic          s2_v_r;
  logic          s2_twice_r, s2_eol_r;
  logic [MW-1:0] s2_r_r, s2_g_r, s2_b_r;
  logic [MW-1:0] mix_r, mix_g, mix_b;

  // stage 3: packed pixel
  logic        s3_v_r;
  logic        s3_twice_r, s3_eol_r;
  logic [15:0] s3_pix_r;
  logic [PW-1:0] q_r, q_g, q_b;
  logic [7:0]  ch_r, ch_g, ch_b;
  logic [15:0] pix565;

  // output register
  logic        o_v_r;
  logic        o_dup_r;   // first of two beats pending
  logic        o_eol_r;
  logic [15:0] o_pix_r;

  function automatic logic [MW-1:0] blend(input logic [7:0] cur, input logic [7:0] prev,
                                          input logic [6:0] wc, input logic [6:0] wp,
                                          input logic on);
    logic [MW-1:0] a;
    logic [MW-1:0] b;
    a = MW'(cur) * MW'(on ? wc : WF);
    b = on ? MW'(prev) * MW'(wp) : '0;
    return a + b;
  endfunction

  always_comb begin
    out_fire = o_v_r && out_ready;
    o_free   = !o_v_r || (out_ready && !o_dup_r);
    ldo      = s3_v_r && o_free;
    s3_free  = !s3_v_r || ldo;
    ld3      = s2_v_r && s3_free;
    s2_free  = !s2_v_r || ld3;
    ld2      = s1_v_r && s2_free;
    s1_free  = !s1_v_r || ld2;
    is_pixel = !head_entry.is_write;
    ld1      = head_valid && is_pixel && s1_free;
    pop      = head_valid && (!is_pixel || s1_free);
    pal_we   = head_valid && !is_pixel && ({1'b0, head_entry.idx} < DEPTH_LIM);
  end

  // duplicated palette: one copy per read address, both written together
  pbh_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_cur (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head_entry.idx[AW-1:0]),
    .wdata (head_entry.rgb),
    .re    (ld1),
    .raddr (head_entry.idx[AW-1:0]),
    .rdata (cur_raw)
  );

  pbh_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_prev (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head_entry.idx[AW-1:0]),
    .wdata (head_entry.rgb),
    .re    (ld1),
    .raddr (head_entry.partner[AW-1:0]),
    .rdata (prev_raw)
  );

  always_comb begin
    cur_c  = s1_cur_oob_r  ? 24'd0 : cur_raw;
    prev_c = s1_prev_oob_r ? 24'd0 : prev_raw;
    mix_r  = blend(cur_c[23:16], prev_c[23:16], WC_R, WP_R, s1_blur_r);
    mix_g  = blend(cur_c[15:8],  prev_c[15:8],  WC_G, WP_G, s1_blur_r);
    mix_b  = blend(cur_c[7:0],   prev_c[7:0],   WC_B, WP_B, s1_blur_r);

    q_r  = PW'(s2_r_r) * PW'(RECIP);
    q_g  = PW'(s2_g_r) * PW'(RECIP);
    q_b  = PW'(s2_b_r) * PW'(RECIP);
    ch_r = q_r[pbh_pkg::RECIP_SHIFT +: 8];
    ch_g = q_g[pbh_pkg::RECIP_SHIFT +: 8];
    ch_b = q_b[pbh_pkg::RECIP_SHIFT +: 8];
    pix565 = (({8'd0, ch_r} >> 3 << 11) & pbh_pkg::MASK_R) |
             (({8'd0, ch_g} >> 2 << 5)  & pbh_pkg::MASK_G) |
             (({8'd0, ch_b} >> 3)       & pbh_pkg::MASK_B);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_blur_r     <= head_entry.blur;
      s1_twice_r    <= head_entry.twice;
      s1_eol_r      <= head_entry.eol;
      s1_cur_oob_r  <= !({1'b0, head_entry.idx} < DEPTH_LIM);
      s1_prev_oob_r <= !({1'b0, head_entry.partner} < DEPTH_LIM);
    end
    if (ld2) begin
      s2_twice_r <= s1_twice_r;
      s2_eol_r   <= s1_eol_r;
      s2_r_r     <= mix_r;
      s2_g_r     <= mix_g;
      s2_b_r     <= mix_b;
    end
    if (ld3) begin
      s3_twice_r <= s2_twice_r;
      s3_eol_r   <= s2_eol_r;
      s3_pix_r   <= pix565;
    end
    if (ldo) begin
      o_eol_r <= s3_eol_r;
      o_pix_r <= s3_pix_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      o_v_r   <= 1'b0;
      o_dup_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_v_r <= 1'b1;
      end else if (ld2) begin
        s1_v_r <= 1'b0;
      end
      if (ld2) begin
        s2_v_r <= 1'b1;
      end else if (ld3) begin
        s2_v_r <= 1'b0;
      end
      if (ld3) begin
        s3_v_r <= 1'b1;
      end else if (ldo) begin
        s3_v_r <= 1'b0;
      end
      if (ldo) begin
        o_v_r   <= 1'b1;
        o_dup_r <= s3_twice_r;
      end else if (out_fire) begin
        if (o_dup_r) begin
          o_dup_r <= 1'b0;
        end else begin
          o_v_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_pixel = o_pix_r;
  assign out_last  = !o_dup_r;
  assign out_eol   = o_eol_r && !o_dup_r;

endmodule

/* hw/rtl/palette_blur_hscale_rgb565_top.sv */
// ============================================================================
// palette_blur_hscale_rgb565_top : palette lookup to RGB565 with blend/stretch
// Pixel path: queue, palette read, weighted sum, divide and pack, output register.
// Throughput: one request per cycle while the queue has room and out_tready is
//   high; a repeated pixel holds the output register for a second beat.
// Reset (rst_n, synchronous, low): clears column, phase, previous pixels,
//   queue and pipeline valids and the config registers; palette is unwritten.
// ============================================================================
module palette_blur_hscale_rgb565_top #(
  parameter int PALETTE_DEPTH = pbh_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input requests
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // index, red, green, blue
  input  logic [1:0]                      in_tuser,   // cmd, line_start
  // output pixels
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // pixel_rgb565
  output logic                            out_tlast,  // last_of_run
  output logic                            out_tuser,  // end_of_line
  // config writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pbh_pkg::cfg_t   cfg_r, cfg_nxt;
  pbh_pkg::entry_t push_entry;
  pbh_pkg::entry_t head_entry;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  logic            in_accept;
  logic            cfg_write;

  // config registers: always ready; written only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (cfg_index)
        pbh_pkg::REG_SCALE_MODE: cfg_nxt.scale_mode  = cfg_data[1:0];
        pbh_pkg::REG_BLUR:       cfg_nxt.blur_enable = cfg_data[0];
        pbh_pkg::REG_CLIP:       cfg_nxt.clip_sides  = cfg_data[0];
        default:                 cfg_nxt = cfg_r;   // unused index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front takes a request whenever the queue has room; dropped pixels
  // still update column state but leave nothing in the queue
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  pbh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (in_accept),
    .cmd        (in_tuser[0]),
    .index      (in_tdata[7:0]),
    .rgb        ({in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]}),
    .line_start (in_tuser[1]),
    .push       (push),
    .push_entry (push_entry)
  );

  pbh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // back: palette writes land in order with pixel reads
  pbh_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pixel  (out_tdata),
    .out_last   (out_tlast),
    .out_eol    (out_tuser)
  );

endmodule
